// File: design/fsp_pkg.sv
package fsp_pkg;

	localparam int NUMBER_BITS = 16;
	localparam int NUM_W = 16;
	localparam int SUM_W = NUM_W + 5;
	localparam logic [NUM_W-1:0] NUM_MAX = (NUMBER_BITS >= NUM_W) ? {NUM_W{1'b1}} :
		NUM_W'((64'd1 << NUMBER_BITS) - 64'd1);

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LO_H  = 8'h68;
	localparam logic [7:0] CH_LO_L  = 8'h6C;
	localparam logic [7:0] CH_LO_J  = 8'h6A;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_LO_T  = 8'h74;
	localparam logic [7:0] CH_UP_L  = 8'h4C;

	localparam logic [2:0] PH_FLAGS  = 3'd0;
	localparam logic [2:0] PH_WDIG   = 3'd1;
	localparam logic [2:0] PH_WDONE  = 3'd2;
	localparam logic [2:0] PH_PSTART = 3'd3;
	localparam logic [2:0] PH_PDIG   = 3'd4;
	localparam logic [2:0] PH_PDONE  = 3'd5;
	localparam logic [2:0] PH_LEN1   = 3'd6;
	localparam logic [2:0] PH_LDONE  = 3'd7;

	localparam logic [1:0] PK_ABSENT = 2'd0;
	localparam logic [1:0] PK_DIGITS = 2'd1;
	localparam logic [1:0] PK_STAR   = 2'd2;

	localparam logic [3:0] LEN_NONE = 4'd0;
	localparam logic [3:0] LEN_H    = 4'd1;
	localparam logic [3:0] LEN_HH   = 4'd2;
	localparam logic [3:0] LEN_L    = 4'd3;
	localparam logic [3:0] LEN_LL   = 4'd4;
	localparam logic [3:0] LEN_J    = 4'd5;
	localparam logic [3:0] LEN_Z    = 4'd6;
	localparam logic [3:0] LEN_T    = 4'd7;
	localparam logic [3:0] LEN_UP_L = 4'd8;

	typedef struct packed {
		logic [2:0]       phase;
		logic [4:0]       flags;
		logic [NUM_W-1:0] width;
		logic             wstar;
		logic [NUM_W-1:0] prec;
		logic [1:0]       pmode;
		logic [3:0]       len;
		logic [7:0]       count;
		logic             ovf;
	} parse_state_t;

	typedef struct packed {
		logic [4:0]       flag_bits;
		logic [NUM_W-1:0] width_value;
		logic             width_from_argument;
		logic [NUM_W-1:0] precision_value;
		logic [1:0]       precision_kind;
		logic [3:0]       length_code;
		logic [7:0]       specifier_char;
		logic [7:0]       chars_consumed;
		logic             number_overflow;
	} parse_result_t;

	localparam parse_state_t STATE_CLEAR = '{
		phase: PH_FLAGS, flags: 5'd0, width: '0, wstar: 1'b0, prec: '0,
		pmode: PK_ABSENT, len: LEN_NONE, count: 8'd0, ovf: 1'b0
	};

endpackage

// File: design/fsp_digit_acc.sv
module fsp_digit_acc (
	input  logic [fsp_pkg::NUM_W-1:0] acc,
	input  logic [7:0]                ch,
	output logic [fsp_pkg::NUM_W-1:0] sum,
	output logic                      sat
);
	import fsp_pkg::*;

	logic [3:0]       dig;
	logic [SUM_W-1:0] raw;

	always_comb begin
		dig = 4'(ch - CH_ZERO);
		raw = SUM_W'(acc) * SUM_W'(10) + SUM_W'(dig);
		sat = (raw > SUM_W'(NUM_MAX));
		sum = sat ? NUM_MAX : raw[NUM_W-1:0];
	end

endmodule

// File: design/fsp_parse_step.sv
module fsp_parse_step (
	input  fsp_pkg::parse_state_t  cur,
	input  logic [7:0]             ch,
	output fsp_pkg::parse_state_t  nxt,
	output logic                   emit,
	output fsp_pkg::parse_result_t res
);
	import fsp_pkg::*;

	logic [NUM_W-1:0] w_sum;
	logic [NUM_W-1:0] p_sum;
	logic             w_sat;
	logic             p_sat;
	logic             is_dig;
	logic             done;
	logic [3:0]       lk;
	logic [7:0]       cnt;

	fsp_digit_acc u_wacc (.acc(cur.width), .ch(ch), .sum(w_sum), .sat(w_sat));
	fsp_digit_acc u_pacc (.acc(cur.prec),  .ch(ch), .sum(p_sum), .sat(p_sat));

	always_comb begin
		is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
		case (ch)
			CH_LO_H: lk = LEN_H;
			CH_LO_L: lk = LEN_L;
			CH_LO_J: lk = LEN_J;
			CH_LO_Z: lk = LEN_Z;
			CH_LO_T: lk = LEN_T;
			CH_UP_L: lk = LEN_UP_L;
			default: lk = LEN_NONE;
		endcase
	end

	always_comb begin
		cnt = (cur.count == 8'hFF) ? cur.count : cur.count + 8'd1;
		nxt = cur;
		nxt.count = cnt;
		done = 1'b0;

		if (cur.phase == PH_FLAGS && ch == CH_MINUS) begin
			nxt.flags[0] = 1'b1;
		end else if (cur.phase == PH_FLAGS && ch == CH_PLUS) begin
			nxt.flags[1] = 1'b1;
		end else if (cur.phase == PH_FLAGS && ch == CH_SPACE) begin
			nxt.flags[2] = 1'b1;
		end else if (cur.phase == PH_FLAGS && ch == CH_HASH) begin
			nxt.flags[3] = 1'b1;
		end else if (cur.phase == PH_FLAGS && ch == CH_ZERO) begin
			nxt.flags[4] = 1'b1;
		end else if (cur.phase == PH_FLAGS && ch == CH_STAR) begin
			nxt.wstar = 1'b1;
			nxt.phase = PH_WDONE;
		end else if ((cur.phase == PH_FLAGS || cur.phase == PH_WDIG) && is_dig) begin
			nxt.width = w_sum;
			nxt.ovf = cur.ovf | w_sat;
			nxt.phase = PH_WDIG;
		end else if (cur.phase <= PH_WDONE && ch == CH_DOT) begin
			nxt.pmode = PK_DIGITS;
			nxt.phase = PH_PSTART;
		end else if (cur.phase == PH_PSTART && ch == CH_STAR) begin
			nxt.pmode = PK_STAR;
			nxt.phase = PH_PDONE;
		end else if ((cur.phase == PH_PSTART || cur.phase == PH_PDIG) && is_dig) begin
			nxt.prec = p_sum;
			nxt.ovf = cur.ovf | p_sat;
			nxt.phase = PH_PDIG;
		end else if (cur.phase == PH_LEN1) begin
			if (cur.len == LEN_H && ch == CH_LO_H) begin
				nxt.len = LEN_HH;
				nxt.phase = PH_LDONE;
			end else if (cur.len == LEN_L && ch == CH_LO_L) begin
				nxt.len = LEN_LL;
				nxt.phase = PH_LDONE;
			end else begin
				done = 1'b1;
			end
		end else if (cur.phase == PH_LDONE) begin
			done = 1'b1;
		end else if (lk != LEN_NONE) begin
			nxt.len = lk;
			nxt.phase = (lk == LEN_H || lk == LEN_L) ? PH_LEN1 : PH_LDONE;
		end else begin
			done = 1'b1;
		end

		res.flag_bits           = cur.flags;
		res.width_value         = cur.width;
		res.width_from_argument = cur.wstar;
		res.precision_value     = (cur.pmode == PK_DIGITS) ? cur.prec : '0;
		res.precision_kind      = cur.pmode;
		res.length_code         = cur.len;
		res.specifier_char      = ch;
		res.chars_consumed      = cnt;
		res.number_overflow     = cur.ovf;

		emit = done;
		if (done) begin
			nxt = STATE_CLEAR;
		end
	end

endmodule

// File: design/format_spec_parser_top.sv
// Conversion specification parser.
// Input channel: in_valid/in_ready with one format character per item, the
// bytes that follow a percent sign. Output channel: out_valid/out_ready with
// one result item per specification, carrying flags, width, precision,
// length modifier, the specifier byte, the byte count and an overflow mark.
// Only the byte that ends a specification produces a result item.
// An item is captured in an input register, parsed combinationally against
// the running parse state, and its result lands in the output register once
// the parse stage advances, which a pending unaccepted result can hold back.
// Throughput is one byte per cycle unless a result waits on the receiver;
// the parse state update (compare set, two times-ten accumulates) sets it.
// Reset clears the input and output register valid bits and the parse
// state, so the next byte starts a new specification.
// When the receiver stalls with a result pending, the parse stage holds its
// byte and in_ready drops once the input register is full; nothing is lost.
module format_spec_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  character,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  flag_bits,
	output logic [15:0] width_value,
	output logic        width_from_argument,
	output logic [15:0] precision_value,
	output logic [1:0]  precision_kind,
	output logic [3:0]  length_code,
	output logic [7:0]  specifier_char,
	output logic [7:0]  chars_consumed,
	output logic        number_overflow
);
	import fsp_pkg::*;

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          advance;
	logic          emit;
	logic          out_valid_q;
	parse_state_t  state_q;
	parse_state_t  state_next;
	parse_result_t res_next;
	parse_result_t res_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	fsp_parse_step u_step (
		.cur  (state_q),
		.ch   (char_s1),
		.nxt  (state_next),
		.emit (emit),
		.res  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= character;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_next;
		end
	end

	assign out_valid           = out_valid_q;
	assign flag_bits           = res_q.flag_bits;
	assign width_value         = res_q.width_value;
	assign width_from_argument = res_q.width_from_argument;
	assign precision_value     = res_q.precision_value;
	assign precision_kind      = res_q.precision_kind;
	assign length_code         = res_q.length_code;
	assign specifier_char      = res_q.specifier_char;
	assign chars_consumed      = res_q.chars_consumed;
	assign number_overflow     = res_q.number_overflow;

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> state_q.phase == PH_FLAGS && state_q.count == 8'd0)
		else $error("parse state not cleared after result");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> chars_consumed != 8'd0)
		else $error("result with zero byte count");

	a_pkind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> precision_kind != 2'd3)
		else $error("bad precision kind");

	a_star: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && width_from_argument |-> width_value == '0)
		else $error("star width with digits");

	a_noloss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("pending result dropped");

endmodule
